// ===== hw/rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, constants and types for the sine/cosine Taylor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

	localparam int SCT_SERIES_TERMS = 16;

	localparam int ANGLE_W   = 24;
	localparam int OUT_W     = 18;
	localparam int FRAC_W    = 26;
	localparam int OUT_SHIFT = 10;

	// reduced angle magnitude, term magnitude and running sums
	localparam int MAG_W  = 29;
	localparam int P_W    = 33;
	localparam int SUM_W  = 36;
	localparam int PROD_W = P_W + MAG_W;
	localparam int N_W    = PROD_W - FRAC_W;
	localparam int NH_W   = N_W / 2;
	localparam int NL_W   = N_W - NH_W;
	localparam int RECIP_W = N_W + 1;

	// quotient estimate for the reduction: |angle| * INV_TWO_PI >> QEST_SHIFT
	localparam int QEST_W     = 14;
	localparam int QEST_SHIFT = 32;
	localparam int QUO_W      = 5;
	localparam int X_W        = ANGLE_W + OUT_SHIFT;

	localparam logic [MAG_W-1:0]  TWO_PI_Q26 = 29'd421657428;
	localparam logic [QEST_W-1:0] INV_TWO_PI = 14'd10430;
	localparam logic [P_W-1:0]    ONE_Q26    = P_W'(1) << FRAC_W;
	localparam logic [OUT_W-1:0]  OUT_ONE    = 18'd65536;

	typedef struct packed {
		logic [MAG_W-1:0]        mag;
		logic                    neg;
		logic signed [SUM_W-1:0] sin_sum;
		logic signed [SUM_W-1:0] cos_sum;
	} sct_ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sct_reduce.sv =====
// ----------------------------------------------------------------------------
// sct_reduce
// Three-stage range reduction: |angle| mod two pi in Q.26, sign kept aside.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_reduce import sct_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      v_out,
	output logic [MAG_W-1:0]          mag,
	output logic                      neg
);

	localparam int QP_W = ANGLE_W + QEST_W;
	localparam int R_W  = MAG_W + 1;

	logic [ANGLE_W-1:0] mag_a;
	logic [QP_W-1:0]    qprod;

	logic               v_s1;
	logic               neg_s1;
	logic [ANGLE_W-1:0] mag_a_s1;
	logic [QP_W-1:0]    qprod_s1;

	logic [QUO_W-1:0]   q0;
	logic [X_W-1:0]     xm;
	logic [X_W-1:0]     qt;
	logic [X_W-1:0]     diff;

	logic               v_s2;
	logic               neg_s2;
	logic [R_W-1:0]     r_s2;

	logic [R_W-1:0]     rsub;

	logic               v_s3;
	logic               neg_s3;
	logic [MAG_W-1:0]   mag_s3;

	// stage 1: magnitude and quotient estimate (short by at most one)
	assign mag_a = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
	assign qprod = QP_W'(mag_a) * QP_W'(INV_TWO_PI);

	// stage 2: remainder against the estimate
	assign q0   = qprod_s1[QEST_SHIFT +: QUO_W];
	assign xm   = {mag_a_s1, {OUT_SHIFT{1'b0}}};
	assign qt   = X_W'(q0) * X_W'(TWO_PI_Q26);
	assign diff = xm - qt;

	// stage 3: one correction step
	assign rsub = r_s2 - R_W'(TWO_PI_Q26);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= angle[ANGLE_W-1];
			mag_a_s1 <= mag_a;
			qprod_s1 <= qprod;
			neg_s2   <= neg_s1;
			r_s2     <= diff[R_W-1:0];
			neg_s3   <= neg_s2;
			mag_s3   <= (r_s2 >= R_W'(TWO_PI_Q26)) ? rsub[MAG_W-1:0] : r_s2[MAG_W-1:0];
		end
	end

	assign v_out = v_s3;
	assign mag   = mag_s3;
	assign neg   = neg_s3;

	a_rem_two_periods: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((MAG_W + 2)'(r_s2) < ((MAG_W + 2)'(TWO_PI_Q26) << 1)))
		else $error("reduction remainder beyond two periods");

	a_rem_one_period: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (mag_s3 < TWO_PI_Q26))
		else $error("reduced angle not below two pi");

endmodule

`default_nettype wire

// ===== hw/rtl/sct_term.sv =====
// ----------------------------------------------------------------------------
// sct_term
// One Taylor step: accumulate the previous term, then p * |x| >> 26, then / K.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_term import sct_pkg::*; #(
	parameter int K = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  logic [P_W-1:0] p_in,
	input  sct_ctx_t       ctx_in,
	output logic           v_out,
	output logic [P_W-1:0] p_out,
	output sct_ctx_t       ctx_out
);

	// the incoming term has index K-1: odd goes to sine, even to cosine
	localparam int J       = K - 1;
	localparam bit ACC_SIN = (J % 2) == 1;
	localparam bit ACC_SUB = ACC_SIN ? (((J - 1) / 2) % 2 == 1) : ((J / 2) % 2 == 1);

	// exact floor(n / K) for n below 2^N_W by reciprocal multiply
	localparam int S = N_W + $clog2(K);
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << S) + 64'(K) - 64'd1) / 64'(K));

	localparam int PP_W  = NH_W + RECIP_W;
	localparam int TOT_W = N_W + RECIP_W;

	logic [PROD_W-1:0]       prod;
	logic signed [SUM_W-1:0] p_ext;
	sct_ctx_t                ctx_a;

	logic                    v_s1;
	logic [N_W-1:0]          n_s1;
	sct_ctx_t                ctx_s1;

	logic                    v_s2;
	logic [PP_W-1:0]         pp_h_s2;
	logic [PP_W-1:0]         pp_l_s2;
	sct_ctx_t                ctx_s2;

	logic [TOT_W-1:0]        total;
	logic [TOT_W-1:0]        quot;

	logic                    v_s3;
	logic [P_W-1:0]          p_s3;
	sct_ctx_t                ctx_s3;

	assign prod  = PROD_W'(p_in) * PROD_W'(ctx_in.mag);
	assign p_ext = $signed({{(SUM_W - P_W){1'b0}}, p_in});

	always_comb begin
		ctx_a = ctx_in;
		if (ACC_SIN) begin
			if (ACC_SUB)
				ctx_a.sin_sum = ctx_in.sin_sum - p_ext;
			else
				ctx_a.sin_sum = ctx_in.sin_sum + p_ext;
		end else begin
			if (ACC_SUB)
				ctx_a.cos_sum = ctx_in.cos_sum - p_ext;
			else
				ctx_a.cos_sum = ctx_in.cos_sum + p_ext;
		end
	end

	assign total = (TOT_W'(pp_h_s2) << NL_W) + TOT_W'(pp_l_s2);
	assign quot  = total >> S;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= prod[FRAC_W +: N_W];
			ctx_s1  <= ctx_a;
			pp_h_s2 <= PP_W'(n_s1[N_W-1:NL_W]) * PP_W'(RECIP);
			pp_l_s2 <= PP_W'(n_s1[NL_W-1:0]) * PP_W'(RECIP);
			ctx_s2  <= ctx_s1;
			p_s3    <= quot[P_W-1:0];
			ctx_s3  <= ctx_s2;
		end
	end

	assign v_out   = v_s3;
	assign p_out   = p_s3;
	assign ctx_out = ctx_s3;

	a_term_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((quot >> P_W) == '0))
		else $error("Taylor term overflows its width");

endmodule

`default_nettype wire

// ===== hw/rtl/sct_round.sv =====
// ----------------------------------------------------------------------------
// sct_round
// Last accumulation, sign fix-up, rounding to Q1.16 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_round import sct_pkg::*; #(
	parameter int SERIES_TERMS = SCT_SERIES_TERMS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    v_in,
	input  logic [P_W-1:0]          p_in,
	input  sct_ctx_t                ctx_in,
	output logic                    v_out,
	output logic signed [OUT_W-1:0] sine_value,
	output logic signed [OUT_W-1:0] cosine_value
);

	// the last term always has an odd index and goes to the sine sum
	localparam int J       = 2 * SERIES_TERMS - 1;
	localparam bit ACC_SUB = ((J - 1) / 2) % 2 == 1;
	localparam int RND_W   = SUM_W - OUT_SHIFT;

	localparam logic [SUM_W-1:0]        HALF    = SUM_W'(1) << (OUT_SHIFT - 1);
	localparam logic signed [OUT_W-1:0] OUT_MAX = $signed(OUT_ONE);
	localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX;

	logic signed [SUM_W-1:0] p_ext;
	logic signed [SUM_W-1:0] sin_f;

	logic                    v_s1;
	logic                    neg_s1;
	logic signed [SUM_W-1:0] sin_s1;
	logic signed [SUM_W-1:0] cos_s1;

	logic                    v_s2;
	logic                    sgn_sin_s2;
	logic                    sgn_cos_s2;
	logic [SUM_W-1:0]        abs_sin_s2;
	logic [SUM_W-1:0]        abs_cos_s2;

	logic [RND_W-1:0]        rnd_sin;
	logic [RND_W-1:0]        rnd_cos;
	logic [OUT_W-1:0]        sat_sin;
	logic [OUT_W-1:0]        sat_cos;

	logic                    v_s3;
	logic signed [OUT_W-1:0] sine_s3;
	logic signed [OUT_W-1:0] cosine_s3;

	assign p_ext = $signed({{(SUM_W - P_W){1'b0}}, p_in});
	assign sin_f = ACC_SUB ? (ctx_in.sin_sum - p_ext) : (ctx_in.sin_sum + p_ext);

	// round half away from zero on the magnitude, then clamp to one
	assign rnd_sin = RND_W'((abs_sin_s2 + HALF) >> OUT_SHIFT);
	assign rnd_cos = RND_W'((abs_cos_s2 + HALF) >> OUT_SHIFT);
	assign sat_sin = (rnd_sin > RND_W'(OUT_ONE)) ? OUT_ONE : rnd_sin[OUT_W-1:0];
	assign sat_cos = (rnd_cos > RND_W'(OUT_ONE)) ? OUT_ONE : rnd_cos[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1     <= ctx_in.neg;
			sin_s1     <= sin_f;
			cos_s1     <= ctx_in.cos_sum;
			// a negative angle flips the sine
			sgn_sin_s2 <= sin_s1[SUM_W-1] ^ neg_s1;
			sgn_cos_s2 <= cos_s1[SUM_W-1];
			abs_sin_s2 <= sin_s1[SUM_W-1] ? SUM_W'(-sin_s1) : SUM_W'(sin_s1);
			abs_cos_s2 <= cos_s1[SUM_W-1] ? SUM_W'(-cos_s1) : SUM_W'(cos_s1);
			sine_s3    <= sgn_sin_s2 ? $signed(-sat_sin) : $signed(sat_sin);
			cosine_s3  <= sgn_cos_s2 ? $signed(-sat_cos) : $signed(sat_cos);
		end
	end

	assign v_out        = v_s3;
	assign sine_value   = sine_s3;
	assign cosine_value = cosine_s3;

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sine_s3 <= OUT_MAX && sine_s3 >= OUT_MIN &&
			cosine_s3 <= OUT_MAX && cosine_s3 >= OUT_MIN))
		else $error("result outside plus or minus one");

endmodule

`default_nettype wire

// ===== hw/rtl/sine_cosine_taylor.sv =====
// Order from input word to result word: range reduction, then for each Taylor term
//   the multiply, the reciprocal products and the quotient, then the final sum,
//   magnitude and rounding.
// Throughput: one word per cycle; a stalled result freezes the whole pipeline in step.
// Reset clears the valid bits only; data registers keep whatever they hold.
// ----------------------------------------------------------------------------
// sine_cosine_taylor
// Pipelined sine and cosine of a Q7.16 angle by truncated Taylor series.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_cosine_taylor import sct_pkg::*; #(
	parameter int SERIES_TERMS = SCT_SERIES_TERMS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [OUT_W-1:0]   sine_value,
	output logic signed [OUT_W-1:0]   cosine_value
);

	localparam int NUM_K = 2 * SERIES_TERMS - 1;

	logic             en;
	logic             red_v;
	logic [MAG_W-1:0] red_mag;
	logic             red_neg;

	logic             v_k   [0:NUM_K];
	logic [P_W-1:0]   p_k   [0:NUM_K];
	sct_ctx_t         ctx_k [0:NUM_K];

	// hold every stage while the result word waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	sct_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.angle  (angle),
		.v_out  (red_v),
		.mag    (red_mag),
		.neg    (red_neg)
	);

	assign v_k[0]   = red_v;
	assign p_k[0]   = ONE_Q26;
	assign ctx_k[0] = '{mag: red_mag, neg: red_neg, sin_sum: '0, cos_sum: '0};

	for (genvar g = 1; g <= NUM_K; g++) begin : g_term
		sct_term #(
			.K (g)
		) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (v_k[g-1]),
			.p_in    (p_k[g-1]),
			.ctx_in  (ctx_k[g-1]),
			.v_out   (v_k[g]),
			.p_out   (p_k[g]),
			.ctx_out (ctx_k[g])
		);
	end

	sct_round #(
		.SERIES_TERMS (SERIES_TERMS)
	) u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.v_in         (v_k[NUM_K]),
		.p_in         (p_k[NUM_K]),
		.ctx_in       (ctx_k[NUM_K]),
		.v_out        (out_valid),
		.sine_value   (sine_value),
		.cosine_value (cosine_value)
	);

endmodule

`default_nettype wire
